>>> sv/vqnc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vqnc_pkg
// Shared types and constants of the nearest-codeword (L1) vector quantizer.
// ----------------------------------------------------------------------------
package vqnc_pkg;

    // default configuration of the core
    localparam int NUM_CODEWORDS_DEF = 8;
    localparam int VECTOR_DIM_DEF    = 16;
    localparam int SAMPLE_BITS_DEF   = 16;

    // fixed field widths
    localparam int VAL_W      = 16;
    localparam int SLOT_W     = 3;
    localparam int POS_W      = 4;
    localparam int ACTIVE_W   = 4;
    localparam int INDEX_W    = 3;
    localparam int DIST_W     = 21;
    localparam int OUT_DIST_W = 20;
    localparam int AD_W       = VAL_W + 1;

    // saturation limits
    localparam logic [DIST_W-1:0]     DIST_MAX     = {DIST_W{1'b1}};
    localparam logic [OUT_DIST_W-1:0] OUT_DIST_MAX = {OUT_DIST_W{1'b1}};

    // reset value of the active codeword count
    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 4'd8;

    // item opcodes
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // control that travels with one codeword through the distance unit
    typedef struct packed {
        logic vld;      // slot holds a codeword update
        logic use_pos;  // element position is inside the vector
        logic first;    // codeword zero
        logic last;     // final codeword of the pass
        logic search;   // vector end and codeword is active
    } sad_tag_t;

endpackage

>>> sv/vqnc_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vqnc_in_if
// Item channel: codebook loads and sample elements with valid/ready.
// ----------------------------------------------------------------------------
interface vqnc_in_if;

    logic                                     valid;
    logic                                     ready;
    logic                                     opcode;
    logic [vqnc_pkg::SLOT_W-1:0]              codeword_slot;
    logic [vqnc_pkg::POS_W-1:0]               element_pos;
    logic signed [vqnc_pkg::VAL_W-1:0]        element_value;
    logic                                     vector_end;

    modport source (
        output valid, opcode, codeword_slot, element_pos, element_value, vector_end,
        input  ready
    );

    modport sink (
        input  valid, opcode, codeword_slot, element_pos, element_value, vector_end,
        output ready
    );

endinterface

>>> sv/vqnc_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vqnc_out_if
// Result channel: nearest codeword index and distance with valid/ready.
// ----------------------------------------------------------------------------
interface vqnc_out_if;

    logic                                valid;
    logic                                ready;
    logic [vqnc_pkg::INDEX_W-1:0]        best_index;
    logic [vqnc_pkg::OUT_DIST_W-1:0]     best_distance;
    logic                                empty_codebook;

    modport source (
        output valid, best_index, best_distance, empty_codebook,
        input  ready
    );

    modport sink (
        input  valid, best_index, best_distance, empty_codebook,
        output ready
    );

endinterface

>>> sv/vq_nearest_codeword_l1_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vq_nearest_codeword_l1_core
// Vector-quantizer encoder: accumulates the L1 distance of a sample vector
// to every stored codeword and reports the nearest one at the vector end.
// ----------------------------------------------------------------------------
//  channel     | dir | handshake     | payload
//  ------------+-----+---------------+-----------------------------------------
//  item_ch     | in  | valid/ready   | opcode, codeword_slot, element_pos,
//              |     |               | element_value, vector_end
//  result_ch   | out | valid/ready   | best_index, best_distance, empty_codebook
//  cfg         | in  | cfg_wr_en     | cfg_wr_data (active codeword count)
//
//  a load item is written to the codebook memory at its transfer, and the
//  block stays ready. a sample item passes the transfer, one issue per
//  codeword with one read per cycle from the codebook memory, and three
//  pipeline stages to drain; on the vector end it also passes the done state.
//  the result sits in an output register; the next item is taken while it
//  waits, and only a new vector end stalls until the old result is taken.
//  reset clears the distances (per-codeword valid bits); the codebook
//  memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module vq_nearest_codeword_l1_core #(
    parameter int NUM_CODEWORDS = vqnc_pkg::NUM_CODEWORDS_DEF,
    parameter int VECTOR_DIM    = vqnc_pkg::VECTOR_DIM_DEF,
    parameter int SAMPLE_BITS   = vqnc_pkg::SAMPLE_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [vqnc_pkg::ACTIVE_W-1:0]    cfg_wr_data,
    vqnc_in_if.sink                          item_ch,
    vqnc_out_if.source                       result_ch
);

    localparam int CW_W     = (NUM_CODEWORDS > 1) ? $clog2(NUM_CODEWORDS) : 1;
    localparam int CB_DEPTH = NUM_CODEWORDS * VECTOR_DIM;
    localparam int AW       = (CB_DEPTH > 1) ? $clog2(CB_DEPTH) : 1;
    localparam int SB       = (SAMPLE_BITS < vqnc_pkg::VAL_W) ? SAMPLE_BITS : vqnc_pkg::VAL_W;
    localparam int CMP_W    = 12;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RUN   = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    localparam logic [CW_W-1:0] K_LAST = CW_W'(NUM_CODEWORDS - 1);

    // memories
    logic [vqnc_pkg::VAL_W-1:0]   cb_mem   [CB_DEPTH];
    logic [vqnc_pkg::DIST_W-1:0]  dist_mem [NUM_CODEWORDS];
    logic [NUM_CODEWORDS-1:0]     dist_vld_reg;
    logic [NUM_CODEWORDS-1:0]     dist_vld_next;

    // control
    logic [1:0]                   state_reg;
    logic [1:0]                   state_next;
    logic [vqnc_pkg::ACTIVE_W-1:0] active_reg;
    logic [CW_W-1:0]              active_cnt;
    logic [CW_W:0]                active_eff;
    logic                         item_xfer;
    logic                         result_xfer;

    // latched item
    logic [vqnc_pkg::POS_W-1:0]   pos_reg;
    logic                         pos_ok_reg;
    logic signed [vqnc_pkg::VAL_W-1:0] smp_reg;
    logic                         end_reg;
    logic signed [vqnc_pkg::VAL_W-1:0] value_ext;
    logic                         load_ok;
    logic [AW-1:0]                load_addr;

    // issue
    logic [CW_W-1:0]              iss_reg;
    logic [AW-1:0]                base_reg;
    logic [AW-1:0]                rd_addr;
    logic                         issuing;
    vqnc_pkg::sad_tag_t           iss_tag;

    // read stage
    vqnc_pkg::sad_tag_t           p0_tag_reg;
    logic [CW_W-1:0]              p0_idx_reg;
    logic                         p0_dvld_reg;
    logic signed [vqnc_pkg::VAL_W-1:0] cb_rd_reg;
    logic [vqnc_pkg::DIST_W-1:0]  dist_rd_reg;
    logic [vqnc_pkg::DIST_W-1:0]  p0_dist;

    // unit output and search
    vqnc_pkg::sad_tag_t           u_tag;
    logic [CW_W-1:0]              u_idx;
    logic [vqnc_pkg::DIST_W-1:0]  u_dist;
    logic [vqnc_pkg::DIST_W-1:0]  best_d_reg;
    logic [CW_W-1:0]              best_i_reg;
    logic                         take_best;

    // result register
    logic                         res_vld_reg;
    logic                         res_vld_next;
    logic                         res_load;
    logic [vqnc_pkg::INDEX_W-1:0] res_idx_reg;
    logic [vqnc_pkg::OUT_DIST_W-1:0] res_dist_reg;
    logic                         res_empty_reg;

    assign item_ch.ready = (state_reg == S_IDLE);
    assign item_xfer     = item_ch.valid && item_ch.ready;
    assign result_xfer   = res_vld_reg && result_ch.ready;

    // sign extension of the low sample bits
    always_comb
    begin
        for (int i = 0; i < vqnc_pkg::VAL_W; i++)
        begin
            value_ext[i] = (i < SB) ? item_ch.element_value[i] : item_ch.element_value[SB-1];
        end
    end

    // codebook load address
    assign load_ok = (item_ch.opcode == vqnc_pkg::OP_LOAD)
                   && (CMP_W'(item_ch.codeword_slot) < CMP_W'(NUM_CODEWORDS))
                   && (CMP_W'(item_ch.element_pos) < CMP_W'(VECTOR_DIM));
    assign load_addr = AW'(AW'(item_ch.codeword_slot) * AW'(VECTOR_DIM))
                     + AW'(item_ch.element_pos);

    // active count saturated to the codebook size
    assign active_eff = (CMP_W'(active_reg) > CMP_W'(NUM_CODEWORDS))
                      ? (CW_W+1)'(NUM_CODEWORDS) : (CW_W+1)'(active_reg);
    assign active_cnt = active_eff[CW_W-1:0];

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= vqnc_pkg::ACTIVE_RESET;
        end
        else if (cfg_wr_en)
        begin
            active_reg <= cfg_wr_data;
        end
    end

    // issue of one codeword per cycle
    assign issuing = (state_reg == S_RUN);
    assign rd_addr = base_reg + (pos_ok_reg ? AW'(pos_reg) : '0);

    always_comb
    begin
        iss_tag.vld     = issuing;
        iss_tag.use_pos = pos_ok_reg;
        iss_tag.first   = (iss_reg == '0);
        iss_tag.last    = (iss_reg == K_LAST);
        iss_tag.search  = end_reg
                        && ((CW_W+1)'(iss_reg) < active_eff);
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        res_load   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (item_xfer && (item_ch.opcode == vqnc_pkg::OP_SAMPLE))
                begin
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (iss_reg == K_LAST)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (u_tag.vld && u_tag.last)
                begin
                    state_next = end_reg ? S_DONE : S_IDLE;
                end
            end
            S_DONE:
            begin
                if (!res_vld_reg || result_ch.ready)
                begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // item latch and issue counters
    always_ff @(posedge clk)
    begin
        if (item_xfer)
        begin
            pos_reg    <= item_ch.element_pos;
            pos_ok_reg <= (CMP_W'(item_ch.element_pos) < CMP_W'(VECTOR_DIM));
            smp_reg    <= value_ext;
            end_reg    <= item_ch.vector_end;
            iss_reg    <= '0;
            base_reg   <= '0;
        end
        else if (issuing)
        begin
            iss_reg  <= iss_reg + 1'b1;
            base_reg <= base_reg + AW'(VECTOR_DIM);
        end
    end

    // codebook memory
    always_ff @(posedge clk)
    begin
        if (item_xfer && load_ok)
        begin
            cb_mem[load_addr] <= value_ext;
        end
        cb_rd_reg <= cb_mem[rd_addr];
    end

    // distance memory
    always_ff @(posedge clk)
    begin
        if (u_tag.vld)
        begin
            dist_mem[u_idx] <= u_dist;
        end
        dist_rd_reg <= dist_mem[iss_reg];
    end

    // distance valid bits: set on write, cleared when a result is loaded into the result register
    always_comb
    begin
        dist_vld_next = dist_vld_reg;
        if (u_tag.vld)
        begin
            dist_vld_next[u_idx] = 1'b1;
        end
        if (res_load)
        begin
            dist_vld_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dist_vld_reg <= '0;
        end
        else
        begin
            dist_vld_reg <= dist_vld_next;
        end
    end

    // read stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p0_tag_reg <= '0;
        end
        else
        begin
            p0_tag_reg <= iss_tag;
        end
    end

    always_ff @(posedge clk)
    begin
        p0_idx_reg  <= iss_reg;
        p0_dvld_reg <= dist_vld_reg[iss_reg];
    end

    assign p0_dist = p0_dvld_reg ? dist_rd_reg : '0;

    vqnc_sad_unit #(
        .IDX_W (CW_W)
    ) u_sad (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_tag    (p0_tag_reg),
        .in_idx    (p0_idx_reg),
        .cw_value  (cb_rd_reg),
        .smp_value (smp_reg),
        .in_dist   (p0_dist),
        .out_tag   (u_tag),
        .out_idx   (u_idx),
        .out_dist  (u_dist)
    );

    // running minimum, lowest index wins ties
    assign take_best = u_tag.vld && u_tag.search && (u_tag.first || (u_dist < best_d_reg));

    always_ff @(posedge clk)
    begin
        if (take_best)
        begin
            best_d_reg <= u_dist;
            best_i_reg <= u_idx;
        end
    end

    // result register
    always_comb
    begin
        res_vld_next = res_vld_reg;
        if (result_xfer)
        begin
            res_vld_next = 1'b0;
        end
        if (res_load)
        begin
            res_vld_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_vld_reg <= 1'b0;
        end
        else
        begin
            res_vld_reg <= res_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            if (active_cnt == '0 && !active_eff[CW_W])
            begin
                res_idx_reg   <= '0;
                res_dist_reg  <= '0;
                res_empty_reg <= 1'b1;
            end
            else
            begin
                res_idx_reg   <= vqnc_pkg::INDEX_W'(best_i_reg);
                res_dist_reg  <= (best_d_reg[vqnc_pkg::DIST_W-1])
                               ? vqnc_pkg::OUT_DIST_MAX
                               : best_d_reg[vqnc_pkg::OUT_DIST_W-1:0];
                res_empty_reg <= 1'b0;
            end
        end
    end

    assign result_ch.valid          = res_vld_reg;
    assign result_ch.best_index     = res_idx_reg;
    assign result_ch.best_distance  = res_dist_reg;
    assign result_ch.empty_codebook = res_empty_reg;

endmodule

>>> sv/vqnc_sad_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vqnc_sad_unit
// Shared two-stage absolute-difference and saturating accumulate unit,
// visited once per codeword for each sample element.
// ----------------------------------------------------------------------------
module vqnc_sad_unit #(
    parameter int IDX_W = 3
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  vqnc_pkg::sad_tag_t                in_tag,
    input  logic [IDX_W-1:0]                  in_idx,
    input  logic signed [vqnc_pkg::VAL_W-1:0] cw_value,
    input  logic signed [vqnc_pkg::VAL_W-1:0] smp_value,
    input  logic [vqnc_pkg::DIST_W-1:0]       in_dist,
    output vqnc_pkg::sad_tag_t                out_tag,
    output logic [IDX_W-1:0]                  out_idx,
    output logic [vqnc_pkg::DIST_W-1:0]       out_dist
);

    vqnc_pkg::sad_tag_t                 a_tag_reg;
    logic [IDX_W-1:0]                   a_idx_reg;
    logic [vqnc_pkg::AD_W-1:0]          ad_reg;
    logic [vqnc_pkg::AD_W-1:0]          ad_next;
    logic [vqnc_pkg::DIST_W-1:0]        a_dist_reg;
    logic signed [vqnc_pkg::AD_W-1:0]   diff;

    vqnc_pkg::sad_tag_t                 b_tag_reg;
    logic [IDX_W-1:0]                   b_idx_reg;
    logic [vqnc_pkg::DIST_W-1:0]        sum_reg;
    logic [vqnc_pkg::DIST_W-1:0]        sum_next;
    logic [vqnc_pkg::DIST_W:0]          sum_wide;

    // absolute difference, zero when the position is outside the vector
    always_comb
    begin
        diff = vqnc_pkg::AD_W'(cw_value) - vqnc_pkg::AD_W'(smp_value);
        if (!in_tag.use_pos)
        begin
            ad_next = '0;
        end
        else if (diff[vqnc_pkg::AD_W-1])
        begin
            ad_next = vqnc_pkg::AD_W'(-diff);
        end
        else
        begin
            ad_next = vqnc_pkg::AD_W'(diff);
        end
    end

    // saturating accumulate
    always_comb
    begin
        sum_wide = (vqnc_pkg::DIST_W+1)'(a_dist_reg) + (vqnc_pkg::DIST_W+1)'(ad_reg);
        if (sum_wide[vqnc_pkg::DIST_W])
        begin
            sum_next = vqnc_pkg::DIST_MAX;
        end
        else
        begin
            sum_next = sum_wide[vqnc_pkg::DIST_W-1:0];
        end
    end

    // stage tags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_tag_reg <= '0;
            b_tag_reg <= '0;
        end
        else
        begin
            a_tag_reg <= in_tag;
            b_tag_reg <= a_tag_reg;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        a_idx_reg  <= in_idx;
        ad_reg     <= ad_next;
        a_dist_reg <= in_dist;
        b_idx_reg  <= a_idx_reg;
        sum_reg    <= sum_next;
    end

    assign out_tag  = b_tag_reg;
    assign out_idx  = b_idx_reg;
    assign out_dist = sum_reg;

endmodule

>>> sv/vqnc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vqnc_checker
// Port-level assertions for the nearest-codeword core, bound to the top.
// ----------------------------------------------------------------------------
module vqnc_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    input  logic                              item_ready,
    input  logic                              item_opcode,
    input  logic                              result_valid,
    input  logic                              result_ready,
    input  logic [vqnc_pkg::INDEX_W-1:0]      best_index,
    input  logic [vqnc_pkg::OUT_DIST_W-1:0]   best_distance,
    input  logic                              empty_codebook
);

    // a stalled result holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(best_index) && $stable(best_distance)
            && $stable(empty_codebook))
    else $error("result changed while stalled");

    // empty codebook reports index and distance zero
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && empty_codebook |-> best_index == '0 && best_distance == '0)
    else $error("empty result carries index or distance");

    // a sample transfer keeps the block busy in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && item_opcode == vqnc_pkg::OP_SAMPLE |=> !item_ready)
    else $error("ready right after a sample transfer");

    // a new result only appears out of the busy search
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> !$past(item_ready))
    else $error("result appeared while idle");

endmodule

bind vq_nearest_codeword_l1_core vqnc_checker u_vqnc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_valid     (item_ch.valid),
    .item_ready     (item_ch.ready),
    .item_opcode    (item_ch.opcode),
    .result_valid   (result_ch.valid),
    .result_ready   (result_ch.ready),
    .best_index     (result_ch.best_index),
    .best_distance  (result_ch.best_distance),
    .empty_codebook (result_ch.empty_codebook)
);
